@@ src/afr_pkg.sv @@
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types, character codes and classification functions for the ASCII
// frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

    localparam int ADDR_W  = 6;
    localparam int COUNT_W = 7;
    localparam int DEPTH   = 64;

    typedef logic [7:0]         byte_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam byte_t CH_OPEN       = 8'h28;
    localparam byte_t CH_CLOSE      = 8'h29;
    localparam byte_t CH_SPACE      = 8'h20;
    localparam byte_t CH_UNDERSCORE = 8'h5F;

    localparam count_t MIN_STORED  = 7'd9;
    localparam count_t CHECK_LIMIT = 7'd5;

    typedef struct packed {
        logic  en;
        addr_t addr;
        byte_t data;
    } mem_wr_t;

    typedef struct packed {
        logic   start;
        count_t length;
    } drain_req_t;

    function automatic logic is_storable(byte_t c);
        return c inside {CH_SPACE, CH_UNDERSCORE, [8'h41:8'h5A], [8'h61:8'h7A],
                         [8'h30:8'h39]};
    endfunction

    function automatic logic is_upper_hex(byte_t c);
        return c inside {[8'h41:8'h46], [8'h30:8'h39]};
    endfunction

endpackage

`default_nettype wire

@@ src/afr_frame_mem.sv @@
// ----------------------------------------------------------------------------
// afr_frame_mem
// Frame character store: one write port and one read port, with the read
// data held in a register until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_frame_mem (
    input  wire logic            clk,
    input  wire afr_pkg::mem_wr_t wr,
    input  wire logic            rd_en,
    input  wire afr_pkg::addr_t  rd_addr,
    output afr_pkg::byte_t       rd_data
);

    afr_pkg::byte_t store_mem [afr_pkg::DEPTH];
    afr_pkg::byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/afr_rx_parser.sv @@
// ----------------------------------------------------------------------------
// afr_rx_parser
// Byte parser: tracks frame acquisition, writes stored characters to the
// frame store and starts a drain when a frame closes correctly.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_rx_parser #(
    parameter int MAX_FRAME_CHARS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire afr_pkg::byte_t      rx_byte,
    output afr_pkg::mem_wr_t         wr,
    output afr_pkg::drain_req_t      drain_req
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ACQ  = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    afr_pkg::count_t count_reg, count_next;
    logic            prev_hex_reg, prev_hex_next;
    logic            last_hex_reg, last_hex_next;
    afr_pkg::count_t count_inc;
    logic            byte_hex;

    assign count_inc = count_reg + 7'd1;
    assign byte_hex  = afr_pkg::is_upper_hex(rx_byte);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        prev_hex_next = prev_hex_reg;
        last_hex_next = last_hex_reg;
        wr            = '0;
        drain_req     = '0;
        if (accept)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte == afr_pkg::CH_OPEN)
                    begin
                        state_next = ST_ACQ;
                        count_next = 7'd1;
                        wr.en      = 1'b1;
                        wr.addr    = '0;
                        wr.data    = rx_byte;
                    end
                end
                ST_ACQ:
                begin
                    if (afr_pkg::is_storable(rx_byte))
                    begin
                        wr.en         = 1'b1;
                        wr.addr       = count_reg[afr_pkg::ADDR_W-1:0];
                        wr.data       = rx_byte;
                        count_next    = count_inc;
                        prev_hex_next = last_hex_reg;
                        last_hex_next = byte_hex;
                        if ((count_inc == 7'(MAX_FRAME_CHARS)) ||
                            (!byte_hex && (count_inc < afr_pkg::CHECK_LIMIT)))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else if (rx_byte == afr_pkg::CH_OPEN)
                    begin
                        count_next = 7'd1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if ((rx_byte == afr_pkg::CH_CLOSE) &&
                            (count_reg >= afr_pkg::MIN_STORED) &&
                            prev_hex_reg && last_hex_reg)
                        begin
                            wr.en            = 1'b1;
                            wr.addr          = count_reg[afr_pkg::ADDR_W-1:0];
                            wr.data          = rx_byte;
                            count_next       = count_inc;
                            drain_req.start  = 1'b1;
                            drain_req.length = count_inc;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            prev_hex_reg <= 1'b0;
            last_hex_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            prev_hex_reg <= prev_hex_next;
            last_hex_reg <= last_hex_next;
        end
    end

endmodule

`default_nettype wire

@@ src/afr_drain.sv @@
// ----------------------------------------------------------------------------
// afr_drain
// Drain sequencer: reads an accepted frame out of the store one character
// per cycle while not stalled, with the position, length and last mark of each.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_drain (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire afr_pkg::drain_req_t drain_req,
    input  wire logic                out_stall,
    output logic                     busy,
    output logic                     rd_en,
    output afr_pkg::addr_t           rd_addr,
    output logic                     out_valid,
    output afr_pkg::addr_t           out_pos,
    output afr_pkg::count_t          out_len,
    output logic                     out_last
);

    typedef enum logic [1:0] {
        DR_IDLE = 2'b01,
        DR_RUN  = 2'b10
    } dstate_t;

    dstate_t         state_reg, state_next;
    afr_pkg::count_t idx_reg, idx_next;
    afr_pkg::count_t len_reg, len_next;
    logic            valid_reg, valid_next;
    afr_pkg::addr_t  pos_reg, pos_next;
    afr_pkg::count_t olen_reg, olen_next;
    logic            last_reg, last_next;
    afr_pkg::count_t idx_inc;
    logic            issue;

    assign idx_inc = idx_reg + 7'd1;
    assign issue   = (state_reg == DR_RUN) && (!valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        valid_next = valid_reg && out_stall;
        pos_next   = pos_reg;
        olen_next  = olen_reg;
        last_next  = last_reg;
        case (state_reg)
            DR_IDLE:
            begin
                if (drain_req.start)
                begin
                    state_next = DR_RUN;
                    idx_next   = '0;
                    len_next   = drain_req.length;
                end
            end
            DR_RUN:
            begin
                if (issue)
                begin
                    valid_next = 1'b1;
                    pos_next   = idx_reg[afr_pkg::ADDR_W-1:0];
                    olen_next  = len_reg;
                    last_next  = (idx_inc == len_reg);
                    idx_next   = idx_inc;
                    if (idx_inc == len_reg)
                    begin
                        state_next = DR_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = DR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DR_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        olen_reg <= olen_next;
    end

    assign busy      = (state_reg == DR_RUN);
    assign rd_en     = issue;
    assign rd_addr   = idx_reg[afr_pkg::ADDR_W-1:0];
    assign out_valid = valid_reg;
    assign out_pos   = pos_reg;
    assign out_len   = olen_reg;
    assign out_last  = last_reg;

`ifndef SYNTHESIS
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        drain_req.start |-> (state_reg == DR_IDLE))
        else $error("drain request while a drain is running");

    a_start_length: assert property (@(posedge clk) disable iff (!rst_n)
        drain_req.start |-> (drain_req.length >= 7'd10 && drain_req.length <= 7'd64))
        else $error("drain request length out of range");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DR_RUN) |-> (idx_reg < len_reg))
        else $error("drain index passed frame length");

    a_pos_before_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> ({1'b0, pos_reg} + 7'd1 < olen_reg))
        else $error("non-final character at or past final position");
`endif

endmodule

`default_nettype wire

@@ src/ascii_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// ascii_frame_receiver
// Receiver for parenthesized ASCII frames on one serial channel.
// ----------------------------------------------------------------------------
// When a closing parenthesis completes a valid frame, the frame is read back
// from the 64-entry character store at one character per cycle, while
// frame_stall is low, through its single read port. An accepted frame holds
// 10 to 64 characters, and rx_stall is high while it is read out. Rejected
// frames and ignored bytes produce no output.
`default_nettype none

module ascii_frame_receiver #(
    parameter int MAX_FRAME_CHARS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             frame_valid,
    input  wire logic        frame_stall,
    output logic [7:0]       frame_byte,
    output logic [5:0]       byte_position,
    output logic [6:0]       frame_length,
    output logic             last_byte
);

    afr_pkg::mem_wr_t    wr;
    afr_pkg::drain_req_t drain_req;
    logic                busy;
    logic                rd_en;
    afr_pkg::addr_t      rd_addr;
    logic                accept;

    assign rx_stall = busy;
    assign accept   = rx_valid && !busy;

    afr_rx_parser #(
        .MAX_FRAME_CHARS(MAX_FRAME_CHARS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .wr        (wr),
        .drain_req (drain_req)
    );

    afr_frame_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (frame_byte)
    );

    afr_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .drain_req (drain_req),
        .out_stall (frame_stall),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .out_valid (frame_valid),
        .out_pos   (byte_position),
        .out_len   (frame_length),
        .out_last  (last_byte)
    );

endmodule

`default_nettype wire
